// ===== design/sqvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite quad vertex setup package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package sqvs_pkg;

  // Quotient bits produced by the pipelined dividers.
  localparam int QuoW = 17;
  // Width of the signed intermediate used before output saturation.
  localparam int ValW = QuoW + 3;

  // Index of the last vertex beat of a sprite (six beats: 0..5).
  localparam logic [2:0] LastBeat = 3'd5;

  // Register indexes on the configuration port.
  localparam logic RegViewportW = 1'b0;
  localparam logic RegViewportH = 1'b1;

  // Angle quadrants.
  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;
  localparam logic [1:0] QuadFourth = 2'd3;

  // Coefficients of the sine approximation, Q16.
  localparam longint unsigned PolyA = 64'd102944;
  localparam longint unsigned PolyB = 64'd42047;
  localparam longint unsigned PolyC = 64'd4639;

  typedef logic signed [ValW-1:0] val_t;

  typedef struct packed {
    logic signed [15:0] dest_left;
    logic signed [15:0] dest_top;
    logic signed [15:0] dest_width;
    logic signed [15:0] dest_height;
    logic signed [15:0] src_left;
    logic signed [15:0] src_top;
    logic signed [15:0] src_width;
    logic signed [15:0] src_height;
    logic [15:0]        turn_angle;
    logic [31:0]        tint_rgba;
    logic [13:0]        texture_width;
    logic [13:0]        texture_height;
  } sprite_t;

  typedef struct packed {
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic [31:0]        vertex_rgba;
    logic               last_vertex;
  } vertex_t;

  // Sideband that travels next to the dividers.
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        neg_u;
    logic        neg_v;
    logic [31:0] rgba;
    logic        last;
  } side_t;

  // Sine of a Q16 angle fraction of a quarter turn, Q1.14, capped at one.
  // Only evaluated on constants to build the quarter-wave table.
  function automatic logic [14:0] sine_poly(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q;
    x2 = (x * x) >> 16;
    t  = (PolyC * x2) >> 16;
    t  = PolyB - t;
    t  = (t * x2) >> 16;
    t  = PolyA - t;
    s  = (t * x) >> 16;
    q  = (s + 64'd2) >> 2;
    if (q > 64'd16384) q = 64'd16384;
    return 15'(q);
  endfunction

  // Corner visited by each vertex beat: 0,1,2,2,1,3.
  function automatic logic [1:0] corner_of(input logic [2:0] beat);
    logic [1:0] c;
    case (beat)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Floor quotient from a magnitude quotient: a negative numerator was
  // divided as its one's complement, so the quotient is complemented too.
  function automatic val_t quo_signed(input logic [QuoW-1:0] m, input logic neg);
    val_t ext;
    ext = val_t'({1'b0, m});
    return neg ? ~ext : ext;
  endfunction

  function automatic logic signed [15:0] sat16(input val_t v);
    logic signed [15:0] r;
    if (v > val_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -val_t'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/sqvs_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sprite quad vertex setup stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface sqvs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/sqvs_div.sv =====
// ----------------------------------------------------------------------------
// Sprite quad vertex setup divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module sqvs_div
  import sqvs_pkg::*;
#(
  parameter int NumW = 32,
  parameter int DenW = 18
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o,
  output logic            ovf_o
);

  localparam int CmpW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [NumW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic            ovf_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int Sh = QuoW - 1 - k;
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic            ovf_in;
    logic [CmpW-1:0] dsh;
    logic            take;

    if (k == 0) begin : g_first
      // The quotient does not fit when num >= den * 2^QuoW.
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign ovf_in = (CmpW'(num_i) >> QuoW) >= CmpW'(den_i);
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    assign dsh  = CmpW'(den_in) << Sh;
    assign take = CmpW'(rem_in) >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? NumW'(CmpW'(rem_in) - dsh) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QuoW-2:0], take};
        ovf_q[k] <= ovf_in;
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];
  assign ovf_o = ovf_q[QuoW-1];

endmodule

// ===== design/sprite_quad_vertex_setup_core.sv =====
// ----------------------------------------------------------------------------
// Sprite quad vertex setup core
// Turns one sprite description into six vertices of two triangles.
// ----------------------------------------------------------------------------
// One sprite beat in gives six vertex beats out, corners 0,1,2,2,1,3, the
// sixth marked with last_vertex. The output channel moves one vertex per
// cycle while the consumer holds ready; a new sprite is taken in the cycle
// the previous one issues its sixth vertex, and also while results wait at
// the output as long as the sprite register is free. The sprite register
// feeds three stages of corner setup (table lookup, multiply, sum), then
// seventeen stages of pipelined division (one quotient bit per stage) and
// finally the output register. The whole vertex pipeline advances
// together whenever the output register is empty or being read.
// Viewport registers sit at byte addresses 0 (width) and 4 (height); a value
// of zero counts as one. Change them only while no sprite is in flight.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup_core
  import sqvs_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqvs_stream_if.sink   sprite_i,
  sqvs_stream_if.source vertex_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam logic [IdxW-1:0] TabN = IdxW'(SINE_TABLE_ENTRIES);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [13:0] vw_q, vh_q;
  logic [13:0] vw_eff, vh_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= 14'd1280;
      vh_q <= 14'd720;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegViewportW: vw_q <= pwdata[13:0];
        RegViewportH: vh_q <= pwdata[13:0];
        default:      vw_q <= vw_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegViewportW: prdata = {18'd0, vw_q};
      RegViewportH: prdata = {18'd0, vh_q};
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign vw_eff = (vw_q == 14'd0) ? 14'd1 : vw_q;
  assign vh_eff = (vh_q == 14'd0) ? 14'd1 : vh_q;

  // --------------------------------------------------------------------------
  // Quarter-wave sine table, built from constants at elaboration.
  // --------------------------------------------------------------------------
  logic [14:0] sine_tab [SINE_TABLE_ENTRIES+1];

  for (genvar i = 0; i <= SINE_TABLE_ENTRIES; i++) begin : g_sine
    localparam longint unsigned XPos = (longint'(i) << 16) / SINE_TABLE_ENTRIES;
    assign sine_tab[i] = sine_poly(XPos);
  end

  // --------------------------------------------------------------------------
  // Sprite register and vertex sequencer.
  // --------------------------------------------------------------------------
  logic        en;
  logic        in_acc;
  logic        busy_q;
  logic [2:0]  cnt_q;
  sprite_t     sprite_q;
  logic        out_valid_q;
  vertex_t     out_q;

  // The whole vertex pipeline moves when the output register can take a beat.
  assign en             = !out_valid_q || vertex_o.ready;
  assign sprite_i.ready = !busy_q || (en && cnt_q == LastBeat);
  assign in_acc         = sprite_i.valid && sprite_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && en) begin
      if (cnt_q == LastBeat) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sprite_q <= sprite_i.data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sine/cosine lookup and corner selection.
  // --------------------------------------------------------------------------
  logic [1:0]          corner;
  logic [1:0]          quad;
  logic [IdxW+13:0]    idx_prod;
  logic [IdxW-1:0]     idx, cidx;
  logic signed [15:0]  s_val, c_val, sn_d, cs_d;
  logic signed [16:0]  dw_x, dh_x;

  assign corner   = corner_of(cnt_q);
  assign quad     = sprite_q.turn_angle[15:14];
  assign idx_prod = (IdxW+14)'(sprite_q.turn_angle[13:0]) * (IdxW+14)'(TabN);
  assign idx      = idx_prod[IdxW+13:14];
  assign cidx     = TabN - idx;
  assign s_val    = 16'($unsigned(sine_tab[idx]));
  assign c_val    = 16'($unsigned(sine_tab[cidx]));
  assign dw_x     = 17'(sprite_q.dest_width);
  assign dh_x     = 17'(sprite_q.dest_height);

  always_comb begin
    case (quad)
      QuadFirst:  begin sn_d = s_val;  cs_d = c_val;  end
      QuadSecond: begin sn_d = c_val;  cs_d = -s_val; end
      QuadThird:  begin sn_d = -s_val; cs_d = -c_val; end
      QuadFourth: begin sn_d = -c_val; cs_d = s_val;  end
      default:    begin sn_d = s_val;  cs_d = c_val;  end
    endcase
  end

  logic               s1_valid_q;
  logic signed [15:0] s1_sn_q, s1_cs_q;
  logic signed [16:0] s1_rx_q, s1_ry_q;
  logic signed [17:0] s1_c2x_q, s1_c2y_q;
  logic signed [16:0] s1_eu_q, s1_ev_q;
  logic [13:0]        s1_tw_q, s1_th_q;
  logic [31:0]        s1_rgba_q;
  logic               s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sn_q   <= sn_d;
      s1_cs_q   <= cs_d;
      s1_rx_q   <= corner[0] ? dw_x : -dw_x;
      s1_ry_q   <= corner[1] ? dh_x : -dh_x;
      // Center doubled, in 1/32 pixel.
      s1_c2x_q  <= 18'(sprite_q.dest_left) * 18'sd2 + 18'(sprite_q.dest_width);
      s1_c2y_q  <= 18'(sprite_q.dest_top) * 18'sd2 + 18'(sprite_q.dest_height);
      s1_eu_q   <= corner[0] ? 17'(sprite_q.src_left) + 17'(sprite_q.src_width)
                             : 17'(sprite_q.src_left);
      s1_ev_q   <= corner[1] ? 17'(sprite_q.src_top) + 17'(sprite_q.src_height)
                             : 17'(sprite_q.src_top);
      s1_tw_q   <= (sprite_q.texture_width == 14'd0) ? 14'd1 : sprite_q.texture_width;
      s1_th_q   <= (sprite_q.texture_height == 14'd0) ? 14'd1 : sprite_q.texture_height;
      s1_rgba_q <= sprite_q.tint_rgba;
      s1_last_q <= (cnt_q == LastBeat);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: rotation products.
  // --------------------------------------------------------------------------
  logic               s2_valid_q;
  logic signed [32:0] s2_cx_q, s2_sy_q, s2_sx_q, s2_cy_q;
  logic signed [17:0] s2_c2x_q, s2_c2y_q;
  logic signed [16:0] s2_eu_q, s2_ev_q;
  logic [13:0]        s2_tw_q, s2_th_q;
  logic [31:0]        s2_rgba_q;
  logic               s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cx_q   <= 33'(s1_cs_q) * 33'(s1_rx_q);
      s2_sy_q   <= 33'(s1_sn_q) * 33'(s1_ry_q);
      s2_sx_q   <= 33'(s1_sn_q) * 33'(s1_rx_q);
      s2_cy_q   <= 33'(s1_cs_q) * 33'(s1_ry_q);
      s2_c2x_q  <= s1_c2x_q;
      s2_c2y_q  <= s1_c2y_q;
      s2_eu_q   <= s1_eu_q;
      s2_ev_q   <= s1_ev_q;
      s2_tw_q   <= s1_tw_q;
      s2_th_q   <= s1_th_q;
      s2_rgba_q <= s1_rgba_q;
      s2_last_q <= s1_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: rounded numerators. Position is in 2^-19 pixel; adding half the
  // divisor turns the floor division into round-to-nearest.
  // --------------------------------------------------------------------------
  logic               s3_valid_q;
  logic signed [32:0] s3_nx_q, s3_ny_q;
  logic signed [26:0] s3_nu_q, s3_nv_q;
  logic [13:0]        s3_tw_q, s3_th_q;
  logic [31:0]        s3_rgba_q;
  logic               s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_nx_q   <= {s2_c2x_q[17], s2_c2x_q, 14'd0} + s2_cx_q - s2_sy_q
                   + 33'({vw_eff, 3'd0});
      s3_ny_q   <= {s2_c2y_q[17], s2_c2y_q, 14'd0} + s2_sx_q + s2_cy_q
                   + 33'({vh_eff, 3'd0});
      s3_nu_q   <= {s2_eu_q[16], s2_eu_q, 9'd0} + 27'(s2_tw_q);
      s3_nv_q   <= {s2_ev_q[16], s2_ev_q, 9'd0} + 27'(s2_th_q);
      s3_tw_q   <= s2_tw_q;
      s3_th_q   <= s2_th_q;
      s3_rgba_q <= s2_rgba_q;
      s3_last_q <= s2_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers. A negative numerator is divided as its one's complement, which
  // gives the floor quotient after complementing the result.
  // --------------------------------------------------------------------------
  logic [QuoW-1:0] qx, qy, qu, qv;
  logic            ox, oy, ou, ov;

  sqvs_div #(.NumW(32), .DenW(18)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s3_nx_q[31:0] ^ {32{s3_nx_q[32]}}),
    .den_i ({vw_eff, 4'd0}),
    .quo_o (qx),
    .ovf_o (ox)
  );

  sqvs_div #(.NumW(32), .DenW(18)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s3_ny_q[31:0] ^ {32{s3_ny_q[32]}}),
    .den_i ({vh_eff, 4'd0}),
    .quo_o (qy),
    .ovf_o (oy)
  );

  sqvs_div #(.NumW(26), .DenW(15)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s3_nu_q[25:0] ^ {26{s3_nu_q[26]}}),
    .den_i ({s3_tw_q, 1'b0}),
    .quo_o (qu),
    .ovf_o (ou)
  );

  sqvs_div #(.NumW(26), .DenW(15)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s3_nv_q[25:0] ^ {26{s3_nv_q[26]}}),
    .den_i ({s3_th_q, 1'b0}),
    .quo_o (qv),
    .ovf_o (ov)
  );

  // Sideband delay line matched to the divider latency.
  logic  sb_valid_q [QuoW];
  side_t sb_q [QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QuoW; k++) sb_valid_q[k] <= 1'b0;
    end else if (en) begin
      sb_valid_q[0] <= s3_valid_q;
      for (int k = 1; k < QuoW; k++) sb_valid_q[k] <= sb_valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= '{neg_x: s3_nx_q[32], neg_y: s3_ny_q[32], neg_u: s3_nu_q[26],
                   neg_v: s3_nv_q[26], rgba: s3_rgba_q, last: s3_last_q};
      for (int k = 1; k < QuoW; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: offset, saturation and the output register.
  // --------------------------------------------------------------------------
  side_t   sb_last;
  val_t    vx, vy, vu, vv;
  vertex_t out_d;

  assign sb_last = sb_q[QuoW-1];
  assign vx = quo_signed(qx, sb_last.neg_x) - val_t'(16384);
  assign vy = val_t'(16384) - quo_signed(qy, sb_last.neg_y);
  assign vu = quo_signed(qu, sb_last.neg_u);
  assign vv = quo_signed(qv, sb_last.neg_v);

  always_comb begin
    out_d.ndc_x       = ox ? (sb_last.neg_x ? -16'sh8000 : 16'sh7fff) : sat16(vx);
    out_d.ndc_y       = oy ? (sb_last.neg_y ? 16'sh7fff : -16'sh8000) : sat16(vy);
    out_d.tex_u       = ou ? (sb_last.neg_u ? -16'sh8000 : 16'sh7fff) : sat16(vu);
    out_d.tex_v       = ov ? (sb_last.neg_v ? -16'sh8000 : 16'sh7fff) : sat16(vv);
    out_d.vertex_rgba = sb_last.rgba;
    out_d.last_vertex = sb_last.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sb_valid_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign vertex_o.valid = out_valid_q;
  assign vertex_o.data  = out_q;

`ifndef ASSERT_OFF
  // A sprite is only taken over a busy sequencer when it issues its last vertex.
  a_accept_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && busy_q) |-> (en && cnt_q == LastBeat))
    else $error("sprite accepted while sequencer is mid-sprite");

  // After the last beat with no new sprite, the sequencer goes idle.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && en && cnt_q == LastBeat && !in_acc) |=> !busy_q)
    else $error("sequencer did not release after the sixth vertex");

  // A stalled pipeline keeps the first stage's beat in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && s1_valid_q) |=> (s1_valid_q && $stable(s1_last_q)))
    else $error("vertex beat lost during a stall");
`endif

endmodule
